FILE: sv/sla_pkg.sv
package sla_pkg;

	localparam int MaxSlabs = 16;
	localparam int MaxObjects = 64;
	localparam int SlotW = 4;
	localparam int ObjW = 6;
	localparam int CntW = 7;
	localparam int LenW = 5;
	localparam int LinkAddrW = SlotW + ObjW;

	typedef enum logic [1:0] {
		CMD_ALLOC   = 2'd0,
		CMD_DEALLOC = 2'd1,
		CMD_REAP    = 2'd2,
		CMD_DESTROY = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_NOMEM  = 2'd1,
		ST_BADHDL = 2'd2,
		ST_BUSY   = 2'd3
	} status_t;

	localparam logic [1:0] RegObjectsPerSlab = 2'd0;

	// Result of one item as handed from the engine to the output stage.
	typedef struct packed {
		logic [1:0]      status;
		logic [SlotW-1:0] slab;
		logic [ObjW-1:0]  obj;
		logic [LenW-1:0]  live;
	} result_t;

endpackage

FILE: sv/slab_object_allocator.sv
// Slab object allocator.
// Commands arrive on the s_axis channel: tdata holds cmd, slab_in and obj_in;
// each command yields exactly one result item on m_axis, whose tdata holds
// status, slab_out, obj_out and live_slabs.
// One item is processed at a time; s_axis_tready is low while it is busy.
// Steps: a dealloc goes straight to the result; an alloc from a usable slab
// reads the free-list head, waits for the RAM, updates the slab and rescans
// the list when the slab fills; an alloc that activates a slab first finds
// the slot and writes every object into the free list.
// Reap and destroy step through every listed slab and compact the list,
// then scan the remaining slabs to choose the preferred slab before the
// result is handed over.
// The free-list links sit in a single-port-write RAM; its port sets the
// activation time.
// The result register holds one item; while the receiver stalls it keeps
// it and the block accepts no further command.
// After reset no slab is active, no slab is preferred and objects_per_slab is 64.
// The user must write this register over APB at address 0 only while idle; not enforced.
module slab_object_allocator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // cmd[1:0], slab_in[5:2], obj_in[11:6]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // status[1:0], slab_out[5:2], obj_out[11:6], live[16:12]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import sla_pkg::*;

	logic [CntW-1:0] ops_q;
	logic [CntW-1:0] full;
	logic            busy_q;
	logic            start;
	logic            done;
	result_t         res;
	result_t         out_q;

	assign pready = 1'b1;
	assign prdata = (paddr == RegObjectsPerSlab) ? {25'd0, ops_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ops_q <= CntW'(MaxObjects);
		end else if (psel && penable && pwrite && paddr == RegObjectsPerSlab) begin
			ops_q <= pwdata[CntW-1:0];
		end
	end

	// Clamp the register to the range 1 .. MaxObjects.
	always_comb begin
		full = ops_q;
		if (ops_q == '0) full = CntW'(1);
		if (ops_q > CntW'(MaxObjects)) full = CntW'(MaxObjects);
	end

	assign s_axis_tready = !busy_q && !m_axis_tvalid;
	assign start = s_axis_tvalid && s_axis_tready;

	sla_engine u_engine (
		.clk(clk), .arst_n(arst_n), .full(full), .start(start),
		.cmd(s_axis_tdata[1:0]), .slab_in(s_axis_tdata[5:2]),
		.obj_in(s_axis_tdata[11:6]), .done(done), .res(res)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (start) busy_q <= 1'b1;
			if (done) begin
				busy_q <= 1'b0;
				m_axis_tvalid <= 1'b1;
				out_q <= res;
			end else if (m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
		end
	end

	assign m_axis_tdata = {7'd0, out_q.live, out_q.obj, out_q.slab, out_q.status};

endmodule

FILE: sv/sla_link_ram.sv
module sla_link_ram (
	input  logic                        clk,
	input  logic                        we,
	input  logic [sla_pkg::LinkAddrW-1:0] waddr,
	input  logic [sla_pkg::ObjW-1:0]      wdata,
	input  logic [sla_pkg::LinkAddrW-1:0] raddr,
	output logic [sla_pkg::ObjW-1:0]      rdata
);
	import sla_pkg::*;

	logic [ObjW-1:0] mem_q [MaxSlabs*MaxObjects];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: sv/sla_engine.sv
module sla_engine (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [sla_pkg::CntW-1:0] full,
	input  logic                 start,
	input  logic [1:0]           cmd,
	input  logic [sla_pkg::SlotW-1:0] slab_in,
	input  logic [sla_pkg::ObjW-1:0]  obj_in,
	output logic                 done,
	output sla_pkg::result_t     res
);
	import sla_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_ACT_FIND, S_ACT_FILL, S_POP_RD, S_POP_WAIT, S_POP_UPD,
		S_SCAN, S_REAP, S_DONE
	} state_t;

	state_t state_q;
	logic [SlotW-1:0] order_q [MaxSlabs];
	logic [LenW-1:0]  len_q;
	logic [MaxSlabs-1:0] active_q;
	logic [CntW-1:0]  used_q [MaxSlabs];
	logic [ObjW-1:0]  head_q [MaxSlabs];
	logic [SlotW-1:0] pref_q;
	logic             pref_v_q;
	logic [1:0]       cmd_q;
	logic [SlotW-1:0] sl_q;
	logic [LenW-1:0]  idx_q;
	logic [LenW-1:0]  kept_q;
	logic [CntW-1:0]  fill_q;
	logic [1:0]       status_q;
	logic [SlotW-1:0] rslab_q;
	logic [ObjW-1:0]  robj_q;
	logic             ram_we;
	logic [LinkAddrW-1:0] ram_waddr;
	logic [ObjW-1:0]  ram_wdata;
	logic [ObjW-1:0]  ram_rdata;
	logic [SlotW-1:0] free_slot;
	logic             free_any;
	logic [SlotW-1:0] cur_s;

	sla_link_ram u_ram (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr({pref_q, head_q[pref_q]}), .rdata(ram_rdata)
	);

	// Lowest inactive slot.
	always_comb begin
		free_slot = '0;
		free_any = 1'b0;
		for (int i = MaxSlabs - 1; i >= 0; i--) begin
			if (!active_q[i]) begin
				free_slot = SlotW'(i);
				free_any = 1'b1;
			end
		end
	end

	assign cur_s = order_q[idx_q[SlotW-1:0]];

	// Link writes: activation fill or dealloc push.
	always_comb begin
		ram_we = 1'b0;
		ram_waddr = {sl_q, fill_q[ObjW-1:0]};
		ram_wdata = (fill_q == '0) ? '0 : ObjW'(fill_q - 1'b1);
		if (state_q == S_ACT_FILL) begin
			ram_we = 1'b1;
		end else if (start && cmd == CMD_DEALLOC && active_q[slab_in] &&
				used_q[slab_in] != '0 && {1'b0, obj_in} < full) begin
			ram_we = 1'b1;
			ram_waddr = {slab_in, obj_in};
			ram_wdata = head_q[slab_in];
		end
	end

	assign done = (state_q == S_DONE);
	assign res = '{status: status_q, slab: rslab_q, obj: robj_q, live: len_q};

	// Sequencer: one step of the list or one fill per cycle; a pop passes through S_POP_RD, S_POP_WAIT and S_POP_UPD.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			len_q <= '0;
			active_q <= '0;
			pref_v_q <= 1'b0;
			pref_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q <= cmd;
						status_q <= ST_OK;
						rslab_q <= '0;
						robj_q <= '0;
						idx_q <= '0;
						kept_q <= '0;
						unique case (cmd_t'(cmd))
							CMD_ALLOC: begin
								if (pref_v_q && used_q[pref_q] < full) begin
									state_q <= S_POP_RD;
								end else begin
									state_q <= S_ACT_FIND;
								end
							end
							CMD_DEALLOC: begin
								if (!active_q[slab_in] || used_q[slab_in] == '0 ||
										{1'b0, obj_in} >= full) begin
									status_q <= ST_BADHDL;
								end else begin
									head_q[slab_in] <= obj_in;
									used_q[slab_in] <= used_q[slab_in] - 1'b1;
									if (!pref_v_q ||
											(used_q[slab_in] - 1'b1) < used_q[pref_q]) begin
										pref_q <= slab_in;
										pref_v_q <= 1'b1;
									end
								end
								state_q <= S_DONE;
							end
							default: state_q <= S_REAP;
						endcase
					end
				end
				S_ACT_FIND: begin
					if (!free_any) begin
						status_q <= ST_NOMEM;
						state_q <= S_DONE;
					end else begin
						active_q[free_slot] <= 1'b1;
						used_q[free_slot] <= '0;
						head_q[free_slot] <= ObjW'(full - 1'b1);
						order_q[len_q[SlotW-1:0]] <= free_slot;
						len_q <= len_q + 1'b1;
						pref_q <= free_slot;
						pref_v_q <= 1'b1;
						sl_q <= free_slot;
						fill_q <= full - 1'b1;
						state_q <= S_ACT_FILL;
					end
				end
				S_ACT_FILL: begin
					// Links written from the top index down; the bottom object links to zero.
					if (fill_q == '0) begin
						state_q <= S_POP_RD;
					end else begin
						fill_q <= fill_q - 1'b1;
					end
				end
				S_POP_RD: state_q <= S_POP_WAIT;
				S_POP_WAIT: begin
					rslab_q <= pref_q;
					robj_q <= head_q[pref_q];
					head_q[pref_q] <= ram_rdata;
					used_q[pref_q] <= used_q[pref_q] + 1'b1;
					state_q <= S_POP_UPD;
				end
				S_POP_UPD: begin
					if (used_q[pref_q] >= full) begin
						pref_v_q <= 1'b0;
						state_q <= S_SCAN;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_SCAN: begin
					// First listed slab that is not full becomes preferred.
					if (idx_q >= len_q) begin
						if (cmd_q == CMD_DESTROY && len_q != '0) begin
							status_q <= ST_BUSY;
						end
						state_q <= S_DONE;
					end else if (used_q[cur_s] < full) begin
						pref_q <= cur_s;
						pref_v_q <= 1'b1;
						if (cmd_q == CMD_DESTROY && len_q != '0) begin
							status_q <= ST_BUSY;
						end
						state_q <= S_DONE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_REAP: begin
					// Compact the list in place, one entry per cycle.
					if (idx_q >= len_q) begin
						len_q <= kept_q;
						idx_q <= '0;
						pref_v_q <= 1'b0;
						state_q <= S_SCAN;
					end else begin
						if (used_q[cur_s] == '0) begin
							active_q[cur_s] <= 1'b0;
						end else begin
							order_q[kept_q[SlotW-1:0]] <= cur_s;
							kept_q <= kept_q + 1'b1;
						end
						idx_q <= idx_q + 1'b1;
					end
				end
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_list_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LenW'(MaxSlabs)) else $error("slab list overflow");
	a_live_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> $countones(active_q) == 32'(len_q))
		else $error("active slots disagree with list length");
	a_pref_active: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && pref_v_q) |-> active_q[pref_q])
		else $error("preferred slab is inactive");

endmodule
